// ----- hdl/ppf_pkg.sv -----
// Shared types and constants for the sub-pixel peak finder.
package ppf_pkg;

    // Port field widths
    localparam int PIX_IN_W   = 16;
    localparam int POS_W      = 20;
    localparam int THR_W      = 16;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Frame height limit and row counter width
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;

    // Log arithmetic: mantissa fraction bits, ln2 and -ln(0.0001) in Q30
    localparam int          MANT_FRAC   = 30;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [63:0] LN_ZERO_Q30 = 64'd9889527671;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_idx_t;

endpackage

// ----- hdl/ppf_stream_if.sv -----
// Handshake channel interfaces: pixel input, result output, configuration write.
interface ppf_pixel_if import ppf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [PIX_IN_W-1:0] pixel_value;
    logic                frame_start;

    modport source (output valid, pixel_value, frame_start, input ready);
    modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface ppf_result_if import ppf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    center_x;
    logic [POS_W-1:0]    center_y;
    logic [PIX_IN_W-1:0] peak_intensity;

    modport source (output valid, center_x, center_y, peak_intensity, input ready);
    modport sink   (input valid, center_x, center_y, peak_intensity, output ready);
endinterface

interface ppf_cfg_if import ppf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/subpixel_particle_peak_finder_core.sv -----
// Sub-pixel particle peak finder: raster pixels in, one (x, y, intensity) request out per
// local maximum. Each pixel passes through line store read, window update and peak test,
// an order set by the read-modify-write of the two line stores. A peak candidate holds
// the input further while the shared iterative log unit takes five logs (each of 30
// squarings, then ln2 scaling; a zero pixel skips them for a fixed value), the shared
// bit-serial divider (DIV_W = LOG_FRAC_BITS + POS_FRAC_BITS + 8 bits) runs once per axis,
// and the fit set-up and the emit are done. A flat line is dropped in the fit set-up
// that follows the five logs. The emit also waits while the previous result
// still sits unaccepted in the output register; otherwise a finished result waits there
// while the next pixels are taken.
module subpixel_particle_peak_finder_core import ppf_pkg::*; #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PIXEL_BITS    = 16,
    parameter int LOG_FRAC_BITS = 11,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ppf_pixel_if.sink pixel,
    ppf_result_if.source result,
    ppf_cfg_if.sink   cfg
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int LN_W   = LOG_FRAC_BITS + 6;
    localparam int NUM_W  = LN_W + 1;
    localparam int DEN_W  = LN_W + 2;
    localparam int DIV_W  = LN_W + POS_FRAC_BITS + 2;

    // order in which the five logs are taken
    localparam logic [2:0] LN_LEFT  = 3'd0;
    localparam logic [2:0] LN_MID   = 3'd1;
    localparam logic [2:0] LN_RIGHT = 3'd2;
    localparam logic [2:0] LN_UP    = 3'd3;
    localparam logic [2:0] LN_DOWN  = 3'd4;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_LOAD     = 9'b000000010,
        S_CHECK    = 9'b000000100,
        S_LN_GO    = 9'b000001000,
        S_LN_WAIT  = 9'b000010000,
        S_PREP     = 9'b000100000,
        S_DIV_GO   = 9'b001000000,
        S_DIV_WAIT = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    state_t                   state_reg;
    logic [THR_W-1:0]         thr_reg;
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic [CW-1:0]            col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [CW-1:0]            item_c_reg;
    logic [ROW_W-1:0]         item_r_reg;
    logic [PIXEL_BITS-1:0]    pix_reg;
    logic [PIXEL_BITS-1:0]    win_reg [9];
    logic [2:0]               ln_idx_reg;
    logic signed [LN_W-1:0]   ln_reg [5];
    logic                     axis_reg;
    logic                     neg_x_reg;
    logic                     neg_y_reg;
    logic [DIV_W-1:0]         dvd_x_reg;
    logic [DIV_W-1:0]         dvs_x_reg;
    logic [DIV_W-1:0]         dvd_y_reg;
    logic [DIV_W-1:0]         dvs_y_reg;
    logic [POS_W-1:0]         cx_reg;
    logic [POS_W-1:0]         cy_reg;
    logic                     out_valid_reg;
    logic [POS_W-1:0]         out_x_reg;
    logic [POS_W-1:0]         out_y_reg;
    logic [PIX_IN_W-1:0]      out_int_reg;

    logic                     pix_acc;
    logic [CW-1:0]            cur_c;
    logic [PIXEL_BITS-1:0]    rd_older;
    logic [PIXEL_BITS-1:0]    rd_newer;
    logic [WW-1:0]            w_cl;
    logic [DIM_W-1:0]         h_cl;
    logic [WW:0]              c_inc;
    logic [DIM_W-1:0]         r_inc;
    logic                     interior;
    logic                     peak;
    logic [PIXEL_BITS-1:0]    ctr;
    logic [PIXEL_BITS-1:0]    ln_in;
    logic                     ln_done;
    logic signed [LN_W-1:0]   ln_out;
    logic signed [NUM_W-1:0]  num_x;
    logic signed [NUM_W-1:0]  num_y;
    logic signed [DEN_W-1:0]  den_x;
    logic signed [DEN_W-1:0]  den_y;
    logic [NUM_W-1:0]         nabs_x;
    logic [NUM_W-1:0]         nabs_y;
    logic [DEN_W-1:0]         dabs_x;
    logic [DEN_W-1:0]         dabs_y;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic [POS_W-1:0]         mag;
    logic [POS_W-1:0]         base;
    logic [CW-1:0]            pos_c;
    logic [ROW_W-1:0]         pos_r;

    // channel handshakes
    assign pix_acc     = pixel.valid && pixel.ready;
    assign pixel.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign cur_c       = pixel.frame_start ? '0 : col_reg;

    assign result.valid          = out_valid_reg;
    assign result.center_x       = out_x_reg;
    assign result.center_y       = out_y_reg;
    assign result.peak_intensity = out_int_reg;

    // line stores
    ppf_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIXEL_BITS),
        .ADDR_W (CW)
    ) u_line_mem (
        .clk      (clk),
        .rd_en    (pix_acc),
        .rd_addr  (cur_c),
        .wr_en    (state_reg == S_LOAD),
        .wr_addr  (item_c_reg),
        .wr_older (rd_newer),
        .wr_newer (pix_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer)
    );

    // clamped frame size
    always_comb
    begin
        if (WW'(width_reg) < WW'(3))
        begin
            w_cl = WW'(3);
        end
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
        begin
            w_cl = WW'(MAX_WIDTH);
        end
        else
        begin
            w_cl = WW'(width_reg);
        end
        if (height_reg < DIM_W'(3))
        begin
            h_cl = DIM_W'(3);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            h_cl = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_cl = height_reg;
        end
    end

    assign c_inc = (WW+1)'(item_c_reg) + (WW+1)'(1);
    assign r_inc = DIM_W'(item_r_reg) + DIM_W'(1);

    // local maximum test on the window
    assign ctr      = win_reg[4];
    assign interior = (item_r_reg >= ROW_W'(2)) && (item_c_reg >= CW'(2))
                   && (DIM_W'(item_r_reg) < h_cl) && (WW'(item_c_reg) < w_cl);

    always_comb
    begin
        peak = (THR_W'(ctr) >= thr_reg);
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4 && win_reg[k] > ctr)
            begin
                peak = 1'b0;
            end
        end
    end

    // log operand select
    always_comb
    begin
        case (ln_idx_reg)
            LN_LEFT:  ln_in = win_reg[3];
            LN_MID:   ln_in = win_reg[4];
            LN_RIGHT: ln_in = win_reg[5];
            LN_UP:    ln_in = win_reg[1];
            default:  ln_in = win_reg[7];
        endcase
    end

    ppf_ln_unit #(
        .PIXEL_BITS    (PIXEL_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_LN_GO),
        .value  (ln_in),
        .done   (ln_done),
        .result (ln_out)
    );

    // numerators and denominators of the three-point fit
    always_comb
    begin
        num_x  = NUM_W'(ln_reg[LN_LEFT]) - NUM_W'(ln_reg[LN_RIGHT]);
        num_y  = NUM_W'(ln_reg[LN_UP]) - NUM_W'(ln_reg[LN_DOWN]);
        den_x  = DEN_W'(ln_reg[LN_LEFT]) - (DEN_W'(ln_reg[LN_MID]) <<< 1)
               + DEN_W'(ln_reg[LN_RIGHT]);
        den_y  = DEN_W'(ln_reg[LN_UP]) - (DEN_W'(ln_reg[LN_MID]) <<< 1)
               + DEN_W'(ln_reg[LN_DOWN]);
        nabs_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
        nabs_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
        dabs_x = den_x[DEN_W-1] ? DEN_W'(-den_x) : DEN_W'(den_x);
        dabs_y = den_y[DEN_W-1] ? DEN_W'(-den_y) : DEN_W'(den_y);
    end

    assign div_start = (state_reg == S_DIV_GO);

    ppf_div_unit #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (axis_reg ? dvd_y_reg : dvd_x_reg),
        .divisor  (axis_reg ? dvs_y_reg : dvs_x_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // integer position of the centre, shifted to fixed point
    assign pos_c = item_c_reg - CW'(1);
    assign pos_r = item_r_reg - ROW_W'(1);
    assign mag   = POS_W'(div_q);
    assign base  = axis_reg ? POS_W'({{POS_W{1'b0}}, pos_r, {POS_FRAC_BITS{1'b0}}})
                            : POS_W'({{POS_W{1'b0}}, pos_c, {POS_FRAC_BITS{1'b0}}});

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= '0;
            width_reg  <= DIM_W'(4096);
            height_reg <= DIM_W'(4096);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_THRESHOLD:    thr_reg    <= cfg.data[THR_W-1:0];
                CFG_IMAGE_WIDTH:  width_reg  <= cfg.data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg.data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            ln_idx_reg    <= LN_LEFT;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            // output register empties on accept; in S_EMIT the emit arm owns it
            if (result.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pix_acc)
                    begin
                        item_c_reg <= cur_c;
                        item_r_reg <= pixel.frame_start ? '0 : row_reg;
                        pix_reg    <= pixel.pixel_value[PIXEL_BITS-1:0];
                        state_reg  <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // window slides one column; counters advance
                    for (int k = 0; k < 3; k++)
                    begin
                        win_reg[k*3]     <= win_reg[k*3+1];
                        win_reg[k*3 + 1] <= win_reg[k*3+2];
                    end
                    win_reg[2] <= rd_older;
                    win_reg[5] <= rd_newer;
                    win_reg[8] <= pix_reg;
                    if (c_inc >= (WW+1)'(w_cl))
                    begin
                        col_reg <= '0;
                        row_reg <= (r_inc >= h_cl) ? '0 : r_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        col_reg <= c_inc[CW-1:0];
                        row_reg <= item_r_reg;
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    ln_idx_reg <= LN_LEFT;
                    state_reg  <= (interior && peak) ? S_LN_GO : S_IDLE;
                end
                S_LN_GO:
                begin
                    state_reg <= S_LN_WAIT;
                end
                S_LN_WAIT:
                begin
                    if (ln_done)
                    begin
                        ln_reg[ln_idx_reg] <= ln_out;
                        if (ln_idx_reg == LN_DOWN)
                        begin
                            state_reg <= S_PREP;
                        end
                        else
                        begin
                            ln_idx_reg <= ln_idx_reg + 3'd1;
                            state_reg  <= S_LN_GO;
                        end
                    end
                end
                S_PREP:
                begin
                    neg_x_reg <= num_x[NUM_W-1] != den_x[DEN_W-1];
                    neg_y_reg <= num_y[NUM_W-1] != den_y[DEN_W-1];
                    dvd_x_reg <= (DIV_W'(nabs_x) << POS_FRAC_BITS) + DIV_W'(dabs_x);
                    dvd_y_reg <= (DIV_W'(nabs_y) << POS_FRAC_BITS) + DIV_W'(dabs_y);
                    dvs_x_reg <= DIV_W'(dabs_x) << 1;
                    dvs_y_reg <= DIV_W'(dabs_y) << 1;
                    axis_reg  <= 1'b0;
                    // flat line on either axis: drop the candidate
                    state_reg <= (den_x == '0 || den_y == '0) ? S_IDLE : S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (!axis_reg)
                        begin
                            cx_reg    <= neg_x_reg ? base - mag : base + mag;
                            axis_reg  <= 1'b1;
                            state_reg <= S_DIV_GO;
                        end
                        else
                        begin
                            cy_reg    <= neg_y_reg ? base - mag : base + mag;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= cx_reg;
                        out_y_reg     <= cy_reg;
                        out_int_reg   <= PIX_IN_W'(ctr);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/ppf_line_mem.sv -----
// Two line stores (rows r-2 and r-1) sharing one address, registered read.
module ppf_line_mem #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_older,
    input  logic [DATA_W-1:0] wr_newer,
    output logic [DATA_W-1:0] rd_older,
    output logic [DATA_W-1:0] rd_newer
);

    logic [DATA_W-1:0] older_mem [DEPTH];
    logic [DATA_W-1:0] newer_mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_older <= older_mem[rd_addr];
            rd_newer <= newer_mem[rd_addr];
        end
    end

endmodule

// ----- hdl/ppf_ln_unit.sv -----
// Iterative fixed-point natural log: log2 by repeated squaring, then scale by ln2.
module ppf_ln_unit import ppf_pkg::*; #(
    parameter int PIXEL_BITS    = 16,
    parameter int LOG_FRAC_BITS = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [PIXEL_BITS-1:0]             value,
    output logic                              done,
    output logic signed [LOG_FRAC_BITS+5:0]   result
);

    localparam int LN_W = LOG_FRAC_BITS + 6;
    localparam int NB   = $clog2(PIXEL_BITS);
    localparam logic [63:0] ZERO_MAG =
        (LN_ZERO_Q30 + (64'd1 << (29 - LOG_FRAC_BITS))) >> (30 - LOG_FRAC_BITS);
    localparam logic [63:0] ROUND_B = 64'd1 << (59 - LOG_FRAC_BITS);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_SQR  = 4'b0010,
        L_MULA = 4'b0100,
        L_MULB = 4'b1000
    } ln_state_t;

    ln_state_t                 state_reg;
    logic [NB-1:0]             exp_reg;
    logic [MANT_FRAC:0]        mant_reg;
    logic [MANT_FRAC-1:0]      frac_reg;
    logic [4:0]                iter_reg;
    logic [59:0]               pfrac_reg;
    logic [NB+29:0]            pexp_reg;
    logic                      done_reg;
    logic signed [LN_W-1:0]    result_reg;

    logic [NB-1:0]             msb_idx;
    logic [2*MANT_FRAC+1:0]    sq;
    logic [MANT_FRAC+1:0]      sq_sh;
    logic [63:0]               prod;

    // leading one position
    always_comb
    begin
        msb_idx = '0;
        for (int i = 0; i < PIXEL_BITS; i++)
        begin
            if (value[i])
            begin
                msb_idx = NB'(i);
            end
        end
    end

    assign sq    = mant_reg * mant_reg;
    assign sq_sh = sq[2*MANT_FRAC+1:MANT_FRAC];
    assign prod  = ({{(34-NB){1'b0}}, pexp_reg} << MANT_FRAC) + {4'b0, pfrac_reg} + ROUND_B;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        if (value == '0)
                        begin
                            result_reg <= -$signed(LN_W'(ZERO_MAG));
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            exp_reg   <= msb_idx;
                            mant_reg  <= (MANT_FRAC+1)'(value) << (5'd30 - 5'(msb_idx));
                            frac_reg  <= '0;
                            iter_reg  <= '0;
                            state_reg <= L_SQR;
                        end
                    end
                end
                L_SQR:
                begin
                    // one fraction bit of log2 per square
                    if (sq_sh[MANT_FRAC+1])
                    begin
                        mant_reg <= sq_sh[MANT_FRAC+1:1];
                        frac_reg <= {frac_reg[MANT_FRAC-2:0], 1'b1};
                    end
                    else
                    begin
                        mant_reg <= sq_sh[MANT_FRAC:0];
                        frac_reg <= {frac_reg[MANT_FRAC-2:0], 1'b0};
                    end
                    if (iter_reg == 5'(MANT_FRAC - 1))
                    begin
                        state_reg <= L_MULA;
                    end
                    iter_reg <= iter_reg + 5'd1;
                end
                L_MULA:
                begin
                    pfrac_reg <= frac_reg * LN2_Q30;
                    pexp_reg  <= exp_reg * LN2_Q30;
                    state_reg <= L_MULB;
                end
                L_MULB:
                begin
                    result_reg <= $signed(LN_W'(prod >> (60 - LOG_FRAC_BITS)));
                    done_reg   <= 1'b1;
                    state_reg  <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hdl/ppf_div_unit.sv -----
// Restoring divider, one quotient bit per cycle.
module ppf_div_unit #(
    parameter int DIV_W = 27
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // shift in next dividend bit, subtract when it fits
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_reg <= DIV_W'(trial - {1'b0, dvs_reg});
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- dv/tb_subpixel_particle_peak_finder_core.sv -----
// Self-checking testbench for the sub-pixel peak finder core: random frames in, checked peaks out.
`timescale 1ns / 1ps

import ppf_pkg::*;

// Expected peak results and the bit-exact predictor of the peak finder
class peak_scoreboard;
    localparam int LOG_FB = 11;
    localparam int POS_FB = 8;
    localparam int WIDTH_LIMIT = 4096;

    typedef struct {
        logic [POS_W-1:0]    cx;
        logic [POS_W-1:0]    cy;
        logic [PIX_IN_W-1:0] level;
    } peak_t;

    peak_t peaks_due[$];
    logic [THR_W-1:0] thr;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [15:0] older_row [WIDTH_LIMIT];
    logic [15:0] newer_row [WIDTH_LIMIT];
    logic [15:0] win [9];
    int unsigned col;
    int unsigned row;
    int mismatches;

    function new();
        thr = '0;
        width_reg = 13'd4096;
        height_reg = 13'd4096;
        foreach (older_row[k]) older_row[k] = '0;
        foreach (newer_row[k]) newer_row[k] = '0;
        foreach (win[k]) win[k] = '0;
        col = 0;
        row = 0;
        mismatches = 0;
    endfunction

    function int pending();
        return peaks_due.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_THRESHOLD:    thr = value[THR_W-1:0];
            CFG_IMAGE_WIDTH:  width_reg = value[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: height_reg = value[DIM_W-1:0];
            default: ;
        endcase
    endfunction

    // Natural log in Q.11 via log2 by repeated squaring
    function longint ln_q(int unsigned v);
        int unsigned n;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned prod;
        n = 0;
        frac = 0;
        if (v == 0)
            return -longint'((LN_ZERO_Q30 + (64'd1 << (29 - LOG_FB))) >> (30 - LOG_FB));
        while (n < 31 && (v >> (n + 1)) != 0) n++;
        m = longint'(v) << (30 - n);
        for (int k = 0; k < 30; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        prod = ((longint'(n) << 30) | frac) * longint'(LN2_Q30);
        return longint'((prod + (64'd1 << (59 - LOG_FB))) >> (60 - LOG_FB));
    endfunction

    // Three-point Gaussian fit on one axis; returns 0 on a flat line
    function bit axis_fit(int unsigned lo, int unsigned mid, int unsigned hi,
                          int unsigned pos, output logic [POS_W-1:0] res);
        longint a, b, c, num, den;
        longint unsigned n, d, mag, base;
        bit neg;
        a = ln_q(lo);
        b = ln_q(mid);
        c = ln_q(hi);
        num = a - c;
        den = a - 2 * b + c;
        res = '0;
        if (den == 0) return 0;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        mag = ((n << POS_FB) + d) / (2 * d);
        base = longint'(pos) << POS_FB;
        if (num == 0) mag = 0;
        res = POS_W'(neg ? (base - mag) : (base + mag));
        return 1;
    endfunction

    // Advance the predictor by one accepted pixel request
    function void note_pixel(logic [15:0] pix, logic fs);
        int unsigned w, h, ctr;
        logic [15:0] up2, up1;
        logic [POS_W-1:0] cx, cy;
        bit is_peak;
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
        if (h < 3) h = 3;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (fs)
        begin
            col = 0;
            row = 0;
        end
        up2 = older_row[col];
        up1 = newer_row[col];
        older_row[col] = up1;
        newer_row[col] = pix;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;
        if (row >= 2 && col >= 2 && row < h && col < w)
        begin
            ctr = win[4];
            is_peak = ctr >= thr;
            for (int k = 0; k < 9; k++)
                if (k != 4 && win[k] > ctr) is_peak = 0;
            if (is_peak && axis_fit(win[3], ctr, win[5], col - 1, cx)
                        && axis_fit(win[1], ctr, win[7], row - 1, cy))
                peaks_due = {peaks_due, peak_t'{cx, cy, ctr[15:0]}};
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
    endfunction

    // Compare one accepted result request with the oldest expected peak
    function void check_result(logic [POS_W-1:0] cx, logic [POS_W-1:0] cy,
                               logic [PIX_IN_W-1:0] level);
        peak_t e;
        if (peaks_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result x=%h y=%h i=%h", cx, cy, level);
            return;
        end
        e = peaks_due.pop_front();
        if (cx !== e.cx || cy !== e.cy || level !== e.level)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: exp x=%h y=%h i=%h, got x=%h y=%h i=%h",
                         e.cx, e.cy, e.level, cx, cy, level);
        end
    endfunction
endclass

module tb_subpixel_particle_peak_finder_core;

    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 40000000;

    logic clk;
    logic rst_n;
    longint cycles;
    bit quiet_src;
    bit quiet_snk;
    int snk_hold;
    int random_sent;
    bit hold_done;

    ppf_pixel_if  pixel();
    ppf_result_if result();
    ppf_cfg_if    cfg();

    peak_scoreboard peaks;

    subpixel_particle_peak_finder_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_subpixel_particle_peak_finder_core NOT OK");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Result side: random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            snk_hold <= 0;
        end
        else if (snk_hold > 0)
        begin
            result.ready <= 1'b0;
            snk_hold <= snk_hold - 1;
        end
        else if (!result.ready)
        begin
            result.ready <= 1'b1;
        end
        else
        begin
            snk_hold <= gap_len(quiet_snk);
            result.ready <= (gap_len(quiet_snk) == 0);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            peaks.check_result(result.center_x, result.center_y, result.peak_intensity);
    end

    // Register write, issued by callers after a drain
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        peaks.write_reg(idx, value);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (peaks.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One pixel request, then an optional gap
    task automatic send_pixel(logic [15:0] value, logic fs);
        int g;
        pixel.valid       <= 1'b1;
        pixel.pixel_value <= value;
        pixel.frame_start <= fs;
        do @(posedge clk); while (!pixel.ready);
        peaks.note_pixel(value, fs);
        g = gap_len(quiet_src);
        if (g > 0)
        begin
            pixel.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Pixel content styles: full range, tiny range (ties, zeros, flats), sparse blobs
    function automatic logic [15:0] make_pixel(int style);
        case (style)
            0: return 16'($urandom_range(16'hFFFF));
            1: return 16'($urandom_range(3));
            2: return ($urandom_range(99) < 8) ? 16'($urandom_range(16'hFFFF, 16'h8000))
                                               : 16'($urandom_range(16'h00FF));
            default: return 16'd500;
        endcase
    endfunction

    // Configure, then stream pixels; frames after the first carry no marker
    task automatic run_frames(logic [15:0] thr, logic [15:0] w, logic [15:0] h,
                              int style, int n_pix, bit count_it);
        drain();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        quiet_src = ($urandom_range(3) == 0);
        quiet_snk = ($urandom_range(3) == 0);
        for (int k = 0; k < n_pix; k++)
        begin
            if (!hold_done && count_it && k == n_pix / 2)
            begin
                hold_done = 1;
                pixel.valid <= 1'b0;
                do @(posedge clk); while (peaks.pending() > 0);
            end
            send_pixel(make_pixel(style), k == 0);
            if (count_it) random_sent++;
        end
        pixel.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_block(logic [15:0] vals[9]);
        foreach (vals[k]) send_pixel(vals[k], k == 0);
        pixel.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] blk [9];
        int w, h, frames;
        peaks = new();
        cycles = 0;
        pixel.valid = 1'b0;
        pixel.pixel_value = '0;
        pixel.frame_start = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_THRESHOLD;
        cfg.data = '0;
        quiet_src = 0;
        quiet_snk = 0;
        random_sent = 0;
        hold_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed: a few pixels at reset sizes, no result possible on row 0
        for (int k = 0; k < 4; k++) send_pixel(k == 0 ? 16'hFFFF : 16'h0000, k == 0);
        pixel.valid <= 1'b0;
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        write_reg(CFG_THRESHOLD, 16'd0);
        // full-scale peak on zero surround
        blk = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0};
        send_block(blk);
        // flat line: dropped
        blk = '{16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7};
        send_block(blk);
        // asymmetric peak, lower-right tie
        blk = '{16'd1, 16'd20, 16'd3, 16'd90, 16'd100, 16'd40, 16'd5, 16'd60, 16'd100};
        send_block(blk);

        // Register extremes and clamping
        run_frames(16'hFFFF, 16'd4, 16'd4, 0, 16, 0);
        run_frames(16'h0000, 16'd0, 16'hFFFF, 2, 60, 0);
        run_frames(16'h0000, 16'd5, 16'd2, 2, 25, 0);
        run_frames(16'h0000, 16'hFFFF, 16'd3, 2, 150, 0);
        run_frames(16'h0000, 16'd4096, 16'd3, 1, 150, 0);

        // Random frames: small sizes mostly, some wrapping without a marker,
        // some cut short by the next marker
        while (random_sent < 1100)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 3);
            h = $urandom_range(8, 3);
            frames = ($urandom_range(4) == 0) ? 2 : 1;
            run_frames(($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                                : 16'($urandom_range(16'h00FF)),
                       16'(w), 16'(h), int'($urandom_range(2)),
                       ($urandom_range(9) == 0) ? int'($urandom_range(w * h - 1, 1))
                                                : w * h * frames, 1);
        end

        drain();
        if (peaks.mismatches == 0 && peaks.pending() == 0)
            $display("tb_subpixel_particle_peak_finder_core OK");
        else
            $display("tb_subpixel_particle_peak_finder_core NOT OK");
        $finish;
    end

endmodule
